// ===== src/tdmh_pkg.sv =====
// ----------------------------------------------------------------------------
// tdmh_pkg
// Shared types and constants for the timer deadline min-heap.
// ----------------------------------------------------------------------------
package tdmh_pkg;

    localparam int CAPACITY = 32;
    localparam int ID_COUNT = 64;
    localparam int TIME_W   = 63;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int POS_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int ST_W     = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_CANCEL = 2'd1,
        OP_EXPIRE = 2'd2
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_CANCELLED = 3'd1,
        ST_EXPIRED   = 3'd2,
        ST_NONE      = 3'd3,
        ST_FULL      = 3'd4,
        ST_DUP       = 3'd5,
        ST_UNKNOWN   = 3'd6
    } t_status;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LOAD,
        CMD_ADD_INIT,
        CMD_CAN_TAKE,
        CMD_LAST_LD,
        CMD_UP_RD,
        CMD_UP_CMP,
        CMD_DN_RD,
        CMD_DN_L,
        CMD_DN_R,
        CMD_DN_CMP,
        CMD_FIN,
        CMD_EXP_POP,
        CMD_RES,
        CMD_EMIT_RD,
        CMD_EMIT_OUT
    } t_cmd;

    typedef struct packed {
        t_cmd    op;
        t_status st;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            present;
        logic            full;
        logic            up_root;
        logic            up_less;
        logic            dn_has_l;
        logic            dn_has_r;
        logic            dn_less;
        logic            moved;
        logic            take_last;
        logic            cnt_one;
        logic            exp_go;
        logic            exp_any;
        logic            emit_last;
    } t_dp_stat;

endpackage

// ===== src/tdmh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdmh_ctrl
// Sequencer for the heap: steps each request through its sift and emit phases.
// ----------------------------------------------------------------------------
module tdmh_ctrl import tdmh_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_dp_stat  i_stat,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_CAN_TAKE, S_LAST_LD, S_UP_RD, S_UP_CMP, S_DN_RD,
        S_DN_L, S_DN_R, S_DN_CMP, S_FIN, S_EXP_CHK, S_RES, S_EMIT_RD, S_EMIT_OUT
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;
    t_cmd    w_op;

    assign busy     = (r_state != S_IDLE);
    assign o_cmd.op = w_op;
    assign o_cmd.st = r_st;

    // choose next step and the command for this cycle
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        w_op    = CMD_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    w_op    = CMD_LOAD;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    OP_ADD: begin
                        if (i_stat.present) begin
                            n_st    = ST_DUP;
                            n_state = S_RES;
                        end else if (i_stat.full) begin
                            n_st    = ST_FULL;
                            n_state = S_RES;
                        end else begin
                            w_op    = CMD_ADD_INIT;
                            n_st    = ST_ADDED;
                            n_state = S_UP_RD;
                        end
                    end
                    OP_CANCEL: begin
                        if (i_stat.present) begin
                            n_st    = ST_CANCELLED;
                            n_state = S_CAN_TAKE;
                        end else begin
                            n_st    = ST_UNKNOWN;
                            n_state = S_RES;
                        end
                    end
                    OP_EXPIRE: begin
                        n_st    = ST_NONE;
                        n_state = S_EXP_CHK;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_CAN_TAKE: begin
                w_op    = CMD_CAN_TAKE;
                n_state = i_stat.take_last ? S_RES : S_LAST_LD;
            end
            S_LAST_LD: begin
                w_op    = CMD_LAST_LD;
                n_state = S_DN_RD;
            end
            S_DN_RD: begin
                w_op = CMD_DN_RD;
                if (i_stat.dn_has_l) begin
                    n_state = S_DN_L;
                end else begin
                    n_state = i_stat.moved ? S_FIN : S_UP_RD;
                end
            end
            S_DN_L: begin
                w_op    = CMD_DN_L;
                n_state = i_stat.dn_has_r ? S_DN_R : S_DN_CMP;
            end
            S_DN_R: begin
                w_op    = CMD_DN_R;
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                w_op = CMD_DN_CMP;
                if (i_stat.dn_less) begin
                    n_state = S_DN_RD;
                end else begin
                    n_state = i_stat.moved ? S_FIN : S_UP_RD;
                end
            end
            S_UP_RD: begin
                w_op    = CMD_UP_RD;
                n_state = i_stat.up_root ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP: begin
                w_op    = CMD_UP_CMP;
                n_state = i_stat.up_less ? S_UP_RD : S_FIN;
            end
            S_FIN: begin
                w_op    = CMD_FIN;
                n_state = (i_stat.op == OP_EXPIRE) ? S_EXP_CHK : S_RES;
            end
            S_EXP_CHK: begin
                if (i_stat.exp_go) begin
                    w_op    = CMD_EXP_POP;
                    n_state = i_stat.cnt_one ? S_EXP_CHK : S_LAST_LD;
                end else if (i_stat.exp_any) begin
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_RES;
                end
            end
            S_RES: begin
                w_op    = CMD_RES;
                n_state = S_IDLE;
            end
            S_EMIT_RD: begin
                w_op    = CMD_EMIT_RD;
                n_state = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                w_op    = CMD_EMIT_OUT;
                n_state = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and result status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_NONE;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

// ===== src/tdmh_dp.sv =====
// ----------------------------------------------------------------------------
// tdmh_dp
// Heap storage, id map, sift registers, expired-id buffer and result registers.
// ----------------------------------------------------------------------------
module tdmh_dp import tdmh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TIME_W-1:0] i_deadline,
    input  logic [TIME_W-1:0] i_now_time,
    output t_dp_stat          o_stat,
    output logic              o_valid,
    output logic [ST_W-1:0]   o_status,
    output logic [ID_W-1:0]   o_expired_id,
    output logic              o_last,
    output logic [TIME_W-1:0] o_earliest_deadline,
    output logic              o_heap_empty,
    output logic              o_rearm,
    output logic [CNT_W-1:0]  o_pending_count
);

    localparam int IDX_W = POS_W + 2;

    // memories
    logic [TIME_W-1:0] heap_d  [CAPACITY];
    logic [ID_W-1:0]   heap_id [CAPACITY];
    logic [POS_W-1:0]  id_pos  [ID_COUNT];
    logic [ID_W-1:0]   exp_buf [CAPACITY];

    // request and sift registers
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_dl, r_now;
    logic [ID_COUNT-1:0] r_present;
    logic [CNT_W-1:0]  r_cnt, r_n, r_k;
    logic [POS_W-1:0]  r_pos, r_cidx;
    logic [TIME_W-1:0] r_cur_d, r_cd, r_rd_d, r_top_d, r_old_top;
    logic [ID_W-1:0]   r_cur_id, r_cid, r_rd_id, r_top_id, r_buf_rd;
    logic [POS_W-1:0]  r_pos_rd;
    logic              r_moved, r_was_empty;

    logic [POS_W-1:0]  w_parent, w_rd_addr, w_wr_addr, w_last_pos;
    logic [IDX_W-1:0]  w_left, w_right;
    logic              w_wr_en;
    logic [TIME_W-1:0] w_wr_d;
    logic [ID_W-1:0]   w_wr_id;
    logic              w_rearm;

    assign w_parent   = POS_W'((r_pos - POS_W'(1)) >> 1);
    assign w_left     = {1'b0, r_pos, 1'b1};
    assign w_right    = w_left + IDX_W'(1);
    assign w_last_pos = POS_W'(r_cnt - CNT_W'(1));

    // status towards the sequencer
    always_comb begin
        o_stat.op        = r_op;
        o_stat.present   = r_present[r_id];
        o_stat.full      = (r_cnt == CNT_W'(CAPACITY));
        o_stat.up_root   = (r_pos == '0);
        o_stat.up_less   = (r_cur_d < r_rd_d);
        o_stat.dn_has_l  = (w_left < IDX_W'(r_cnt));
        o_stat.dn_has_r  = (w_right < IDX_W'(r_cnt));
        o_stat.dn_less   = (r_cd < r_cur_d);
        o_stat.moved     = r_moved;
        o_stat.take_last = (r_pos_rd == w_last_pos);
        o_stat.cnt_one   = (r_cnt == CNT_W'(1));
        o_stat.exp_go    = (r_cnt != '0) && (r_top_d <= r_now);
        o_stat.exp_any   = (r_n != '0);
        o_stat.emit_last = (r_k == r_n - CNT_W'(1));
    end

    // heap read address and write port
    always_comb begin
        w_rd_addr = '0;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_d    = r_cur_d;
        w_wr_id   = r_cur_id;
        unique case (i_cmd.op)
            CMD_UP_RD:    w_rd_addr = w_parent;
            CMD_CAN_TAKE,
            CMD_EXP_POP:  w_rd_addr = w_last_pos;
            CMD_DN_RD:    w_rd_addr = w_left[POS_W-1:0];
            CMD_DN_L:     w_rd_addr = w_right[POS_W-1:0];
            CMD_UP_CMP: begin
                w_wr_en = (r_cur_d < r_rd_d);
                w_wr_d  = r_rd_d;
                w_wr_id = r_rd_id;
            end
            CMD_DN_CMP: begin
                w_wr_en = (r_cd < r_cur_d);
                w_wr_d  = r_cd;
                w_wr_id = r_cid;
            end
            CMD_FIN:      w_wr_en = 1'b1;
            default:      w_rd_addr = '0;
        endcase
    end

    // rearm for the single-result case
    always_comb begin
        if (i_cmd.st == ST_ADDED) begin
            w_rearm = r_was_empty || (r_top_d < r_old_top);
        end else if (r_op == OP_EXPIRE) begin
            w_rearm = (r_cnt != '0);
        end else begin
            w_rearm = 1'b0;
        end
    end

    // memories: registered reads, one write each
    always_ff @(posedge i_clk) begin
        r_rd_d   <= heap_d[w_rd_addr];
        r_rd_id  <= heap_id[w_rd_addr];
        r_pos_rd <= id_pos[r_id];
        r_buf_rd <= exp_buf[r_k[POS_W-1:0]];
        if (w_wr_en) begin
            heap_d[w_wr_addr]  <= w_wr_d;
            heap_id[w_wr_addr] <= w_wr_id;
            id_pos[w_wr_id]    <= w_wr_addr;
        end
        if (i_cmd.op == CMD_EXP_POP) begin
            exp_buf[r_n[POS_W-1:0]] <= r_top_id;
        end
    end

    // mirror the heap top
    always_ff @(posedge i_clk) begin
        if (w_wr_en && (w_wr_addr == '0)) begin
            r_top_d  <= w_wr_d;
            r_top_id <= w_wr_id;
        end
    end

    // payload registers of the sift and the registered result outputs
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            CMD_LOAD: begin
                r_op  <= i_operation;
                r_id  <= i_timer_id;
                r_dl  <= i_deadline;
                r_now <= i_now_time;
            end
            CMD_ADD_INIT: begin
                r_cur_d     <= r_dl;
                r_cur_id    <= r_id;
                r_pos       <= POS_W'(r_cnt);
                r_was_empty <= (r_cnt == '0);
                r_old_top   <= r_top_d;
            end
            CMD_CAN_TAKE: r_pos <= r_pos_rd;
            CMD_EXP_POP:  r_pos <= '0;
            CMD_LAST_LD: begin
                r_cur_d  <= r_rd_d;
                r_cur_id <= r_rd_id;
            end
            CMD_UP_CMP: begin
                if (r_cur_d < r_rd_d) begin
                    r_pos <= w_parent;
                end
            end
            CMD_DN_L: begin
                r_cd   <= r_rd_d;
                r_cid  <= r_rd_id;
                r_cidx <= w_left[POS_W-1:0];
            end
            CMD_DN_R: begin
                if (r_rd_d < r_cd) begin
                    r_cd   <= r_rd_d;
                    r_cid  <= r_rd_id;
                    r_cidx <= w_right[POS_W-1:0];
                end
            end
            CMD_DN_CMP: begin
                if (r_cd < r_cur_d) begin
                    r_pos <= r_cidx;
                end
            end
            default: r_pos <= r_pos;
        endcase
        o_expired_id <= (i_cmd.op == CMD_RES) ? '0 : r_buf_rd;
        o_status     <= (i_cmd.op == CMD_EMIT_OUT) ? ST_EXPIRED : i_cmd.st;
        o_last       <= (i_cmd.op == CMD_RES) || o_stat.emit_last;
        o_earliest_deadline <= (r_cnt != '0) ? r_top_d : '0;
        o_heap_empty    <= (r_cnt == '0);
        o_pending_count <= r_cnt;
        o_rearm         <= (i_cmd.op == CMD_EMIT_OUT) ? (r_cnt != '0) : w_rearm;
    end

    // control registers: count, presence, moved flag, buffer pointers, strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_present <= '0;
            r_moved   <= 1'b0;
            r_n       <= '0;
            r_k       <= '0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= (i_cmd.op == CMD_RES) || (i_cmd.op == CMD_EMIT_OUT);
            unique case (i_cmd.op)
                CMD_LOAD: begin
                    r_n <= '0;
                    r_k <= '0;
                end
                CMD_ADD_INIT: begin
                    r_cnt           <= r_cnt + CNT_W'(1);
                    r_present[r_id] <= 1'b1;
                end
                CMD_CAN_TAKE: begin
                    r_cnt           <= r_cnt - CNT_W'(1);
                    r_present[r_id] <= 1'b0;
                end
                CMD_EXP_POP: begin
                    r_cnt               <= r_cnt - CNT_W'(1);
                    r_present[r_top_id] <= 1'b0;
                    r_n                 <= r_n + CNT_W'(1);
                end
                CMD_LAST_LD: r_moved <= 1'b0;
                CMD_DN_CMP: begin
                    if (r_cd < r_cur_d) begin
                        r_moved <= 1'b1;
                    end
                end
                CMD_EMIT_OUT: r_k <= r_k + CNT_W'(1);
                default:      r_moved <= r_moved;
            endcase
        end
    end

endmodule

// ===== src/timer_deadline_min_heap.sv =====
// ----------------------------------------------------------------------------
// timer_deadline_min_heap
// Indexed binary min-heap of pending timers with add, cancel by id and expire.
// ----------------------------------------------------------------------------
// Hold start high with a request on the inputs; it is taken at the first rising
// edge at which busy is low. Results cannot be held off: each appears for a
// single cycle with o_valid high and must be captured then. The heap sits in
// memories with registered reads, so every sift level steps through its own
// read and compare states. A rejected add or cancel goes straight to its
// result; an add sifts its entry up level by level; a cancel that frees the
// last slot needs no sift, any other moves the last entry into the freed slot
// and sifts it down, or up if it did not move; an expire that finds nothing
// due reports none, else it pops each due timer in turn and then emits one
// result per popped timer, all carrying the final top deadline and count. The
// last result leaves in the same cycle that busy falls.
module timer_deadline_min_heap import tdmh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TIME_W-1:0] i_deadline,
    input  logic [TIME_W-1:0] i_now_time,
    output logic              o_valid,
    output logic [ST_W-1:0]   o_status,
    output logic [ID_W-1:0]   o_expired_id,
    output logic              o_last,
    output logic [TIME_W-1:0] o_earliest_deadline,
    output logic              o_heap_empty,
    output logic              o_rearm,
    output logic [CNT_W-1:0]  o_pending_count
);

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // sequencer
    tdmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // heap datapath
    tdmh_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_operation         (i_operation),
        .i_timer_id          (i_timer_id),
        .i_deadline          (i_deadline),
        .i_now_time          (i_now_time),
        .o_stat              (w_stat),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_expired_id        (o_expired_id),
        .o_last              (o_last),
        .o_earliest_deadline (o_earliest_deadline),
        .o_heap_empty        (o_heap_empty),
        .o_rearm             (o_rearm),
        .o_pending_count     (o_pending_count)
    );

endmodule

// ===== tb/heap_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heap_checker
// Watches the request and result channels of the timer deadline min-heap,
// keeps its own indexed heap in step with each accepted request and compares
// every result field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module heap_checker import tdmh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [ID_W-1:0]   i_timer_id,
    input  logic [TIME_W-1:0] i_deadline,
    input  logic [TIME_W-1:0] i_now_time,
    input  logic              i_valid,
    input  logic [ST_W-1:0]   i_status,
    input  logic [ID_W-1:0]   i_expired_id,
    input  logic              i_last,
    input  logic [TIME_W-1:0] i_earliest_deadline,
    input  logic              i_heap_empty,
    input  logic              i_rearm,
    input  logic [CNT_W-1:0]  i_pending_count,
    output int                o_fail_count,
    output int                o_outstanding
);

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   expired_id;
        logic              last;
        logic [TIME_W-1:0] earliest;
        logic              empty;
        logic              rearm;
        logic [CNT_W-1:0]  count;
    } t_timer_result;

    // Shadow heap
    logic [TIME_W-1:0] shadow_dl [CAPACITY];
    logic [ID_W-1:0]   shadow_id [CAPACITY];
    int                slot_of   [ID_COUNT];
    logic              pending   [ID_COUNT];
    int                heap_size;

    t_timer_result timer_results_due[$];
    int            fail_count;
    int            outstanding_n;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outstanding_n;

    function automatic void swap_slots(int a, int b);
        logic [TIME_W-1:0] d;
        logic [ID_W-1:0]   t;
        d = shadow_dl[a]; t = shadow_id[a];
        shadow_dl[a] = shadow_dl[b]; shadow_id[a] = shadow_id[b];
        shadow_dl[b] = d; shadow_id[b] = t;
        slot_of[shadow_id[a]] = a;
        slot_of[shadow_id[b]] = b;
    endfunction

    function automatic void sift_up(int p);
        int parent;
        while (p > 0) begin
            parent = (p - 1) / 2;
            if (shadow_dl[p] < shadow_dl[parent]) begin
                swap_slots(p, parent);
                p = parent;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void sift_down(int p);
        int child;
        child = 2 * p + 1;
        while (child < heap_size) begin
            if (child + 1 < heap_size && shadow_dl[child + 1] < shadow_dl[child])
                child++;
            if (shadow_dl[child] < shadow_dl[p]) begin
                swap_slots(child, p);
                p     = child;
                child = 2 * p + 1;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void remove_slot(int p);
        pending[shadow_id[p]] = 1'b0;
        heap_size--;
        if (p < heap_size) begin
            swap_slots(p, heap_size);
            sift_down(p);
            sift_up(p);
        end
    endfunction

    // Apply one request to the shadow heap and queue the results it causes
    function automatic void predict_timer_request(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                                                  logic [TIME_W-1:0] dl,
                                                  logic [TIME_W-1:0] now_t);
        t_timer_result     batch[$];
        t_timer_result     r;
        logic              rearm;
        logic              was_empty;
        logic [TIME_W-1:0] old_top;
        rearm = 1'b0;
        r     = '0;
        case (op)
            OP_ADD: begin
                if (pending[tid]) begin
                    r.status = ST_DUP; batch = {batch, r};
                end else if (heap_size >= CAPACITY) begin
                    r.status = ST_FULL; batch = {batch, r};
                end else begin
                    was_empty = (heap_size == 0);
                    old_top   = was_empty ? '0 : shadow_dl[0];
                    shadow_dl[heap_size] = dl;
                    shadow_id[heap_size] = tid;
                    slot_of[tid] = heap_size;
                    pending[tid] = 1'b1;
                    heap_size++;
                    sift_up(heap_size - 1);
                    rearm = was_empty || (shadow_dl[0] < old_top);
                    r.status = ST_ADDED; batch = {batch, r};
                end
            end
            OP_CANCEL: begin
                if (!pending[tid]) begin
                    r.status = ST_UNKNOWN; batch = {batch, r};
                end else begin
                    remove_slot(slot_of[tid]);
                    r.status = ST_CANCELLED; batch = {batch, r};
                end
            end
            OP_EXPIRE: begin
                while (heap_size > 0 && shadow_dl[0] <= now_t) begin
                    r.status     = ST_EXPIRED;
                    r.expired_id = shadow_id[0];
                    batch = {batch, r};
                    remove_slot(0);
                end
                if (batch.size() == 0) begin
                    r.status = ST_NONE; batch = {batch, r};
                end
                rearm = (heap_size > 0);
            end
            default: return;
        endcase
        // Stamp the post-operation heap view on every result of the request
        foreach (batch[k]) begin
            batch[k].last     = (k == batch.size() - 1);
            batch[k].earliest = (heap_size > 0) ? shadow_dl[0] : '0;
            batch[k].empty    = (heap_size == 0);
            batch[k].rearm    = rearm;
            batch[k].count    = heap_size[CNT_W-1:0];
            timer_results_due = {timer_results_due, batch[k]};
        end
    endfunction

    initial begin
        heap_size     = 0;
        fail_count    = 0;
        outstanding_n = 0;
        foreach (pending[i]) pending[i] = 1'b0;
    end

    // Compare results first, then take in the request accepted at this edge
    always @(posedge i_clk) begin
        t_timer_result got;
        t_timer_result want;
        if (i_rst_n) begin
            if (i_valid) begin
                got = '{i_status, i_expired_id, i_last, i_earliest_deadline,
                        i_heap_empty, i_rearm, i_pending_count};
                if (timer_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with none outstanding: status %0d id %0d",
                                 $time, i_status, i_expired_id);
                end else begin
                    want = timer_results_due.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: result mismatch", $time);
                            $display({"  expected st %0d id %0d last %0b top %0d",
                                      " empty %0b rearm %0b cnt %0d"},
                                     want.status, want.expired_id, want.last,
                                     want.earliest, want.empty, want.rearm, want.count);
                            $display({"  actual   st %0d id %0d last %0b top %0d",
                                      " empty %0b rearm %0b cnt %0d"},
                                     got.status, got.expired_id, got.last,
                                     got.earliest, got.empty, got.rearm, got.count);
                        end
                    end
                end
            end
            if (i_start && !i_busy)
                predict_timer_request(i_operation, i_timer_id, i_deadline, i_now_time);
            outstanding_n = timer_results_due.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random add, cancel, expire and reserved-op requests into the timer
// deadline min-heap with random gaps; the checker beside it judges results.
// ----------------------------------------------------------------------------
module tb_top import tdmh_pkg::*;;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [OP_W-1:0]   OP_RESERVED = 2'd3;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_operation;
    logic [ID_W-1:0]   i_timer_id;
    logic [TIME_W-1:0] i_deadline;
    logic [TIME_W-1:0] i_now_time;
    logic              o_valid;
    logic [ST_W-1:0]   o_status;
    logic [ID_W-1:0]   o_expired_id;
    logic              o_last;
    logic [TIME_W-1:0] o_earliest_deadline;
    logic              o_heap_empty;
    logic              o_rearm;
    logic [CNT_W-1:0]  o_pending_count;

    int                fail_count;
    int                outstanding;
    int                cycle_count = 0;
    logic [TIME_W-1:0] time_base;
    logic              gaps_on;

    timer_deadline_min_heap u_dut (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_timer_id, .i_deadline,
        .i_now_time, .o_valid, .o_status, .o_expired_id, .o_last,
        .o_earliest_deadline, .o_heap_empty, .o_rearm, .o_pending_count
    );

    heap_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_operation,
        .i_timer_id, .i_deadline, .i_now_time, .i_valid(o_valid),
        .i_status(o_status), .i_expired_id(o_expired_id), .i_last(o_last),
        .i_earliest_deadline(o_earliest_deadline), .i_heap_empty(o_heap_empty),
        .i_rearm(o_rearm), .i_pending_count(o_pending_count),
        .o_fail_count(fail_count), .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [TIME_W-1:0] wide_random();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [TIME_W-1:0] pick_deadline();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return wide_random();
        if (r < 20) return TIME_W'($urandom_range(0, 3));
        return time_base + TIME_W'($urandom_range(0, 300));
    endfunction

    // Present one request and hold it until the heap takes it
    task automatic issue(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                         logic [TIME_W-1:0] dl, logic [TIME_W-1:0] now_t);
        start       <= 1'b1;
        i_operation <= op;
        i_timer_id  <= tid;
        i_deadline  <= dl;
        i_now_time  <= now_t;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (gaps_on && $urandom_range(0, 99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    initial begin
        int r;
        time_base   = TIME_W'(1000);
        gaps_on     = 1'b0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_ADD;
        i_timer_id  <= '0;
        i_deadline  <= '0;
        i_now_time  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap, duplicates, ties, root cancel, reserved op
        issue(OP_EXPIRE, ID_W'(0), '0, TIME_MAX);
        issue(OP_CANCEL, ID_W'(5), '0, '0);
        issue(OP_ADD, ID_W'(5), TIME_MAX, '0);
        issue(OP_ADD, ID_W'(6), '0, '0);
        issue(OP_ADD, ID_W'(5), TIME_W'(7), '0);
        issue(OP_ADD, ID_W'(7), '0, '0);
        issue(OP_ADD, ID_W'(8), '0, '0);
        issue(OP_CANCEL, ID_W'(6), '0, '0);
        issue(OP_CANCEL, ID_W'(6), '0, '0);
        issue(OP_RESERVED, ID_W'(9), TIME_MAX, TIME_MAX);
        issue(OP_EXPIRE, ID_W'(63), '0, '0);
        issue(OP_EXPIRE, ID_W'(0), '0, TIME_MAX - TIME_W'(1));
        issue(OP_EXPIRE, ID_W'(0), '0, TIME_MAX);
        // Fill with descending deadlines, overflow, cancel one, then drain in one go
        for (int k = 0; k < CAPACITY; k++)
            issue(OP_ADD, ID_W'(10 + k), TIME_W'(1000 - k), '0);
        issue(OP_ADD, ID_W'(63), TIME_W'(1), '0);
        issue(OP_CANCEL, ID_W'(20), '0, '0);
        issue(OP_EXPIRE, ID_W'(0), '0, TIME_MAX);

        // Random: alternating fill-heavy and mixed stretches
        gaps_on = 1'b1;
        for (int n = 0; n < 300; n++) begin
            gaps_on = !(n >= 150 && n < 250);
            r = $urandom_range(0, 99);
            if ((n % 100) < 50 ? r < 80 : r < 40) begin
                issue(OP_ADD, ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 63))
                                                            : ID_W'($urandom_range(0, 39)),
                      pick_deadline(), wide_random());
            end else if (r < 88) begin
                issue(OP_CANCEL, ID_W'($urandom_range(0, 39)), wide_random(), wide_random());
            end else if (r < 97) begin
                r = $urandom_range(0, 99);
                issue(OP_EXPIRE, ID_W'($urandom), wide_random(),
                      (r < 10) ? TIME_MAX : (r < 15) ? '0
                                          : time_base + TIME_W'($urandom_range(0, 300)));
                time_base = time_base + TIME_W'($urandom_range(0, 150));
            end else begin
                issue(OP_RESERVED, ID_W'($urandom), wide_random(), wide_random());
            end
        end
        start <= 1'b0;

        // Drain
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/tdmh_pkg.sv
src/tdmh_ctrl.sv
src/tdmh_dp.sv
src/timer_deadline_min_heap.sv
tb/heap_checker.sv
tb/tb_top.sv
